[rtl/core/cbp_pkg.sv]
package cbp_pkg;

    // coordinate and register width
    localparam int COORD_BITS = 12;
    localparam int FRAME_BITS = 32;
    localparam int GRAD_BITS  = 8;
    localparam int BAR_BITS   = 3;
    localparam int BAR_COUNT  = 8;
    localparam int BW_BITS    = COORD_BITS - BAR_BITS;
    localparam int SCAN_LEN   = 16;

    // restoring divider chain: both dividends are zero-extended to one width
    // and consumed MSB first
    localparam int STEPS      = 4;
    localparam int MOD_BITS   = FRAME_BITS + 3;
    localparam int GNUM_BITS  = COORD_BITS + GRAD_BITS;
    localparam int DIV_RAW    = (MOD_BITS > GNUM_BITS) ? MOD_BITS : GNUM_BITS;
    localparam int DIV_BITS   = ((DIV_RAW + STEPS - 1) / STEPS) * STEPS;
    localparam int DIV_STAGES = DIV_BITS / STEPS;

    // register map, decoded on paddr[2]
    localparam int  ADDR_BITS        = 3;
    localparam logic CFG_IDX_WIDTH   = 1'b0;
    localparam logic CFG_IDX_HEIGHT  = 1'b1;
    localparam logic [COORD_BITS-1:0] WIDTH_RESET  = COORD_BITS'(1280);
    localparam logic [COORD_BITS-1:0] HEIGHT_RESET = COORD_BITS'(720);

    // colors
    localparam logic [31:0] BAR_COLORS [BAR_COUNT] = '{
        32'hFFFFFFFF, 32'hFF00FFFF, 32'hFFFFFF00, 32'hFF00FF00,
        32'hFFFF00FF, 32'hFF0000FF, 32'hFFFF0000, 32'hFF000000
    };
    localparam logic [31:0] SCAN_COLOR = 32'hFF00E5FF;
    localparam logic [31:0] GRAD_BASE  = 32'hFF000000;

    typedef struct packed {
        logic [COORD_BITS-1:0] frame_width;
        logic [COORD_BITS-1:0] frame_height;
    } t_cfg;

    // per-beat payload through the divider chain
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic                  is_bar;
        logic [BAR_BITS-1:0]   bar;
        logic [COORD_BITS-1:0] g_rem;
        logic [DIV_BITS-1:0]   g_num;
        logic [GRAD_BITS-1:0]  g_quo;
        logic [COORD_BITS-1:0] s_rem;
        logic [DIV_BITS-1:0]   s_num;
    } t_div_beat;

endpackage

[rtl/core/color_bar_test_pattern_pixel.sv]
// Color bar test pattern, one pixel per clock. A beat is taken on every cycle
// with start high (busy stays low), and its color word comes out on
// o_pixel_word with o_done high for one cycle, after one front stage (bar
// index, band split), nine divider stages of four restoring steps each
// (gradient quotient and scan start, 36 dividend bits) and the output
// register. The receiver cannot stall; results must be taken when o_done is
// high. Registers: frame_width at 0x0, frame_height at 0x4, which the user
// must write over the APB port only while no pixel is in flight (not enforced).
module color_bar_test_pattern_pixel (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [cbp_pkg::COORD_BITS-1:0]      i_pixel_x,
    input  logic [cbp_pkg::COORD_BITS-1:0]      i_pixel_y,
    input  logic [cbp_pkg::FRAME_BITS-1:0]      i_frame_number,
    output logic                                o_done,
    output logic [31:0]                         o_pixel_word,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cbp_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    cbp_pkg::t_cfg      w_cfg;
    logic               w_valid [cbp_pkg::DIV_STAGES+1];
    cbp_pkg::t_div_beat w_beat  [cbp_pkg::DIV_STAGES+1];

    assign busy = 1'b0;

    // configuration registers
    cbp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // bar index, band split, divider setup
    cbp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_valid        (start & ~busy),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_frame_number (i_frame_number),
        .o_valid        (w_valid[0]),
        .o_beat         (w_beat[0])
    );

    // divider chain
    for (genvar s = 0; s < cbp_pkg::DIV_STAGES; s++) begin : g_div
        cbp_div_stage u_div (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_frame_width (w_cfg.frame_width),
            .i_valid       (w_valid[s]),
            .i_beat        (w_beat[s]),
            .o_valid       (w_valid[s+1]),
            .o_beat        (w_beat[s+1])
        );
    end

    // color select and output register
    cbp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_width (w_cfg.frame_width),
        .i_valid       (w_valid[cbp_pkg::DIV_STAGES]),
        .i_beat        (w_beat[cbp_pkg::DIV_STAGES]),
        .o_done        (o_done),
        .o_pixel_word  (o_pixel_word)
    );

endmodule

[rtl/core/cbp_cfg.sv]
module cbp_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cbp_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output cbp_pkg::t_cfg                       o_cfg
);

    cbp_pkg::t_cfg r_cfg;
    logic          w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    // register writes, word decode on bit 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= cbp_pkg::WIDTH_RESET;
            r_cfg.frame_height <= cbp_pkg::HEIGHT_RESET;
        end else if (w_wr) begin
            case (paddr[2])
                cbp_pkg::CFG_IDX_WIDTH:
                    r_cfg.frame_width  <= pwdata[cbp_pkg::COORD_BITS-1:0];
                cbp_pkg::CFG_IDX_HEIGHT:
                    r_cfg.frame_height <= pwdata[cbp_pkg::COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // readback
    always_comb begin
        case (paddr[2])
            cbp_pkg::CFG_IDX_WIDTH:  prdata = 32'(r_cfg.frame_width);
            cbp_pkg::CFG_IDX_HEIGHT: prdata = 32'(r_cfg.frame_height);
            default:                 prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/cbp_front.sv]
module cbp_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cbp_pkg::t_cfg                       i_cfg,
    input  logic                                i_valid,
    input  logic [cbp_pkg::COORD_BITS-1:0]      i_pixel_x,
    input  logic [cbp_pkg::COORD_BITS-1:0]      i_pixel_y,
    input  logic [cbp_pkg::FRAME_BITS-1:0]      i_frame_number,
    output logic                                o_valid,
    output cbp_pkg::t_div_beat                  o_beat
);

    localparam int CB = cbp_pkg::COORD_BITS;

    logic               r_valid;
    cbp_pkg::t_div_beat r_beat;
    cbp_pkg::t_div_beat n_beat;

    logic [cbp_pkg::BW_BITS-1:0]    w_bw;
    logic [cbp_pkg::BAR_COUNT-2:0]  w_past;
    logic [CB+1:0]                  w_h3;
    logic [CB-1:0]                  w_split;
    logic [cbp_pkg::GNUM_BITS-1:0]  w_x255;

    assign w_bw    = i_cfg.frame_width[CB-1:cbp_pkg::BAR_BITS];
    assign w_h3    = {i_cfg.frame_height, 1'b0} + (CB+2)'(i_cfg.frame_height);
    assign w_split = w_h3[CB+1:2];
    assign w_x255  = {i_pixel_x, 8'd0} - cbp_pkg::GNUM_BITS'(i_pixel_x);

    // bar index: count of bar edges k*bw at or left of x, clamps at 7
    always_comb begin
        for (int k = 1; k < cbp_pkg::BAR_COUNT; k++) begin
            w_past[k-1] = (i_pixel_x >= (CB'(w_bw) * CB'(k)));
        end
    end

    always_comb begin
        n_beat        = '0;
        n_beat.x      = i_pixel_x;
        n_beat.is_bar = (i_pixel_y < w_split);
        if (w_bw == '0)
            n_beat.bar = cbp_pkg::BAR_BITS'(cbp_pkg::BAR_COUNT - 1);
        else
            n_beat.bar = cbp_pkg::BAR_BITS'($countones(w_past));
        n_beat.g_num  = cbp_pkg::DIV_BITS'(w_x255);
        n_beat.s_num  = cbp_pkg::DIV_BITS'({i_frame_number, 3'b000});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_valid <= 1'b0;
        else
            r_valid <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        r_beat <= n_beat;
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

[rtl/core/cbp_div_stage.sv]
module cbp_div_stage (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [cbp_pkg::COORD_BITS-1:0]      i_frame_width,
    input  logic                                i_valid,
    input  cbp_pkg::t_div_beat                  i_beat,
    output logic                                o_valid,
    output cbp_pkg::t_div_beat                  o_beat
);

    localparam int CB = cbp_pkg::COORD_BITS;

    logic               r_valid;
    cbp_pkg::t_div_beat r_beat;
    cbp_pkg::t_div_beat n_beat;

    // four restoring steps each for gradient quotient and scan remainder
    always_comb begin
        logic [CB-1:0]                 g_rem;
        logic [CB-1:0]                 s_rem;
        logic [CB:0]                   g_t;
        logic [CB:0]                   s_t;
        logic [cbp_pkg::DIV_BITS-1:0]  g_num;
        logic [cbp_pkg::DIV_BITS-1:0]  s_num;
        logic [cbp_pkg::GRAD_BITS-1:0] g_quo;
        g_rem = i_beat.g_rem;
        s_rem = i_beat.s_rem;
        g_num = i_beat.g_num;
        s_num = i_beat.s_num;
        g_quo = i_beat.g_quo;
        for (int i = 0; i < cbp_pkg::STEPS; i++) begin
            g_t   = {g_rem, g_num[cbp_pkg::DIV_BITS-1]};
            s_t   = {s_rem, s_num[cbp_pkg::DIV_BITS-1]};
            g_num = g_num << 1;
            s_num = s_num << 1;
            if (g_t >= {1'b0, i_frame_width}) begin
                g_rem = CB'(g_t - {1'b0, i_frame_width});
                g_quo = {g_quo[cbp_pkg::GRAD_BITS-2:0], 1'b1};
            end else begin
                g_rem = g_t[CB-1:0];
                g_quo = {g_quo[cbp_pkg::GRAD_BITS-2:0], 1'b0};
            end
            if (s_t >= {1'b0, i_frame_width})
                s_rem = CB'(s_t - {1'b0, i_frame_width});
            else
                s_rem = s_t[CB-1:0];
        end
        n_beat       = i_beat;
        n_beat.g_rem = g_rem;
        n_beat.s_rem = s_rem;
        n_beat.g_num = g_num;
        n_beat.s_num = s_num;
        n_beat.g_quo = g_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_valid <= 1'b0;
        else
            r_valid <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        r_beat <= n_beat;
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

[rtl/core/cbp_back.sv]
module cbp_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [cbp_pkg::COORD_BITS-1:0]      i_frame_width,
    input  logic                                i_valid,
    input  cbp_pkg::t_div_beat                  i_beat,
    output logic                                o_done,
    output logic [31:0]                         o_pixel_word
);

    localparam int CB = cbp_pkg::COORD_BITS;

    logic        r_done;
    logic [31:0] r_word;
    logic [31:0] n_word;

    logic                          w_wzero;
    logic [CB-1:0]                 w_scan;
    logic [CB:0]                   w_scan_end;
    logic [cbp_pkg::GRAD_BITS-1:0] w_grad;
    logic                          w_in_scan;

    // zero width forces gradient 0 and scan start 0
    assign w_wzero    = (i_frame_width == '0);
    assign w_scan     = w_wzero ? '0 : i_beat.s_rem;
    assign w_grad     = w_wzero ? '0 : i_beat.g_quo;
    assign w_scan_end = {1'b0, w_scan} + (CB+1)'(cbp_pkg::SCAN_LEN);
    assign w_in_scan  = (i_beat.x >= w_scan) && ({1'b0, i_beat.x} < w_scan_end);

    // color select
    always_comb begin
        if (i_beat.is_bar)
            n_word = cbp_pkg::BAR_COLORS[i_beat.bar];
        else if (w_in_scan)
            n_word = cbp_pkg::SCAN_COLOR;
        else
            n_word = cbp_pkg::GRAD_BASE | (32'(w_grad) << 8) | 32'(w_grad >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_done <= 1'b0;
        else
            r_done <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_done       = r_done;
    assign o_pixel_word = r_word;

    // every color carries full alpha
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_pixel_word[31:24] == 8'hFF))
        else $error("result beat without full alpha");

    // no result beat right after reset
    a_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_done)
        else $error("result beat after reset");

    // a gradient word has blue equal to half of green
    a_grad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_pixel_word[23:16] == 8'h00) && (o_pixel_word != cbp_pkg::SCAN_COLOR)
            && (o_pixel_word != cbp_pkg::BAR_COLORS[1])
            && (o_pixel_word != cbp_pkg::BAR_COLORS[3])
            && (o_pixel_word != cbp_pkg::BAR_COLORS[5]))
        |-> (o_pixel_word[7:0] == {1'b0, o_pixel_word[15:9]}))
        else $error("gradient blue byte is not half of green");

endmodule

[verif/color_bar_checker.sv]
// Watches the pixel and APB channels of the color bar pattern block, predicts
// the color word of every accepted pixel beat and compares it with the
// o_done results in order.
module color_bar_checker
    import cbp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [COORD_BITS-1:0] i_pixel_x,
    input  logic [COORD_BITS-1:0] i_pixel_y,
    input  logic [FRAME_BITS-1:0] i_frame_number,
    input  logic                  i_done,
    input  logic [31:0]           i_pixel_word,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [ADDR_BITS-1:0]  i_paddr,
    input  logic [31:0]           i_pwdata,
    input  logic                  i_pready,
    output int                    o_mismatch_count,
    output int                    o_pixels_in_flight
);

    // expected palette, kept apart from the design's own table
    localparam logic [31:0] BAR_WORDS [8] = '{
        32'hFFFFFFFF, 32'hFF00FFFF, 32'hFFFFFF00, 32'hFF00FF00,
        32'hFFFF00FF, 32'hFF0000FF, 32'hFFFF0000, 32'hFF000000
    };
    localparam logic [31:0] SCAN_WORD   = 32'hFF00E5FF;
    localparam logic [31:0] OPAQUE_BASE = 32'hFF000000;
    localparam int          SCAN_WIDTH  = 16;

    typedef struct {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [FRAME_BITS-1:0] frame;
        logic [31:0]           word;
    } pixel_beat_t;

    pixel_beat_t           pending_pixels[$];
    logic [COORD_BITS-1:0] frame_width;
    logic [COORD_BITS-1:0] frame_height;
    int                    mismatches = 0;
    int                    in_flight  = 0;

    assign o_mismatch_count   = mismatches;
    assign o_pixels_in_flight = in_flight;

    // color of one pixel under the given frame geometry
    function automatic logic [31:0] pattern_word(
        input logic [COORD_BITS-1:0] x,
        input logic [COORD_BITS-1:0] y,
        input logic [FRAME_BITS-1:0] frame,
        input logic [COORD_BITS-1:0] width,
        input logic [COORD_BITS-1:0] height
    );
        int unsigned           split;
        int unsigned           bar_width;
        int unsigned           bar;
        int unsigned           scan;
        logic [7:0]            level;
        logic [31:0]           word;
        split = (int'(height) * 3) / 4;
        if (int'(y) < split) begin
            // vertical bars, narrow frames fall back to black
            bar_width = int'(width) / 8;
            bar = 7;
            if (bar_width != 0) begin
                bar = int'(x) / bar_width;
                if (bar > 7) bar = 7;
            end
            word = BAR_WORDS[bar];
        end else begin
            // gradient band with the moving scan bar
            level = 8'd0;
            scan = 0;
            if (width != 0) begin
                level = 8'((20'(x) * 20'd255) / 20'(width));
                scan  = int'((35'(frame) << 3) % 35'(width));
            end
            word = OPAQUE_BASE | {16'd0, level, 8'd0} | {24'd0, level >> 1};
            if (int'(x) >= scan && int'(x) < scan + SCAN_WIDTH) word = SCAN_WORD;
        end
        return word;
    endfunction

    always @(posedge i_clk) begin
        pixel_beat_t beat;
        if (!i_rst_n) begin
            frame_width  <= WIDTH_RESET;
            frame_height <= HEIGHT_RESET;
            pending_pixels.delete();
            in_flight <= 0;
        end else begin
            // register writes track the geometry used for prediction
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == CFG_IDX_WIDTH) frame_width <= i_pwdata[COORD_BITS-1:0];
                else frame_height <= i_pwdata[COORD_BITS-1:0];
            end
            // result beat against the oldest prediction
            if (i_done) begin
                if (pending_pixels.size() == 0) begin
                    mismatches <= mismatches + 1;
                    $display("%0t: unexpected pixel_word %08h, nothing pending",
                             $time, i_pixel_word);
                end else begin
                    beat = pending_pixels.pop_front();
                    if (i_pixel_word !== beat.word) begin
                        mismatches <= mismatches + 1;
                        $display("%0t: pixel_word x=%0d y=%0d frame=%0d: expected %08h, got %08h",
                                 $time, beat.x, beat.y, beat.frame, beat.word, i_pixel_word);
                    end
                end
            end
            // accepted pixel beat
            if (i_start && !i_busy) begin
                beat.x     = i_pixel_x;
                beat.y     = i_pixel_y;
                beat.frame = i_frame_number;
                beat.word  = pattern_word(i_pixel_x, i_pixel_y, i_frame_number,
                                          frame_width, frame_height);
                pending_pixels.push_back(beat);
            end
            in_flight <= pending_pixels.size();
        end
    end

endmodule

[verif/tb_color_bar_test_pattern_pixel.sv]
module tb_color_bar_test_pattern_pixel;
    import cbp_pkg::*;

    localparam int PIXELS_PER_PHASE = 170;
    localparam int PHASES           = 10;
    localparam int TOTAL_PIXELS     = 18 + PIXELS_PER_PHASE * PHASES;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  start          = 1'b0;
    logic [COORD_BITS-1:0] i_pixel_x      = '0;
    logic [COORD_BITS-1:0] i_pixel_y      = '0;
    logic [FRAME_BITS-1:0] i_frame_number = '0;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [ADDR_BITS-1:0]  paddr          = '0;
    logic [31:0]           pwdata         = '0;
    logic                  busy;
    logic                  o_done;
    logic [31:0]           o_pixel_word;
    logic [31:0]           prdata;
    logic                  pready;
    int                    mismatch_count;
    int                    pixels_in_flight;
    int                    beats_sent     = 0;
    logic [COORD_BITS-1:0] cur_width      = WIDTH_RESET;
    logic [COORD_BITS-1:0] cur_height     = HEIGHT_RESET;

    color_bar_test_pattern_pixel dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_frame_number (i_frame_number),
        .o_done         (o_done),
        .o_pixel_word   (o_pixel_word),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    color_bar_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_pixel_x          (i_pixel_x),
        .i_pixel_y          (i_pixel_y),
        .i_frame_number     (i_frame_number),
        .i_done             (o_done),
        .i_pixel_word       (o_pixel_word),
        .i_psel             (psel),
        .i_penable          (penable),
        .i_pwrite           (pwrite),
        .i_paddr            (paddr),
        .i_pwdata           (pwdata),
        .i_pready           (pready),
        .o_mismatch_count   (mismatch_count),
        .o_pixels_in_flight (pixels_in_flight)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // random idle cycles whose odds depend on the run section, then one pixel beat
    task automatic send_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                              input logic [FRAME_BITS-1:0] frame);
        int unsigned idle_pct;
        if (beats_sent < TOTAL_PIXELS / 3) idle_pct = 28;
        else if (beats_sent < 2 * TOTAL_PIXELS / 3) idle_pct = 67;
        else idle_pct = 0;
        // each cycle idles with the section's odds
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_pixel_x      <= x;
        i_pixel_y      <= y;
        i_frame_number <= frame;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        beats_sent++;
    endtask

    // hold off until every predicted pixel has come back
    task automatic drain_pixels();
        start <= 1'b0;
        @(posedge i_clk);
        while (pixels_in_flight != 0) @(posedge i_clk);
    endtask

    // APB write, junk in the bits above the register
    task automatic write_reg(input logic idx, input logic [COORD_BITS-1:0] value);
        logic [31:0] junk;
        junk = $urandom;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk[31:COORD_BITS], value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_IDX_WIDTH) cur_width = value;
        else cur_height = value;
    endtask

    // mostly in-frame pixels, gradient ones clustered around the scan bar
    task automatic send_random_pixel();
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [FRAME_BITS-1:0] frame;
        int unsigned           split;
        int unsigned           scan;
        int unsigned           kind;
        kind  = $urandom_range(0, 99);
        frame = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom;
        x     = COORD_BITS'($urandom);
        y     = COORD_BITS'($urandom);
        split = (int'(cur_height) * 3) / 4;
        if (kind < 40) begin
            if (cur_width != 0) x = COORD_BITS'($urandom_range(0, int'(cur_width) - 1));
            if (split != 0) y = COORD_BITS'($urandom_range(0, split - 1));
        end else if (kind < 85) begin
            if (int'(cur_height) > split)
                y = COORD_BITS'($urandom_range(split, int'(cur_height) - 1));
            if (cur_width != 0) begin
                scan = int'((35'(frame) << 3) % 35'(cur_width));
                if (kind < 65) x = COORD_BITS'(scan + $urandom_range(0, 17) - 1);
                else x = COORD_BITS'($urandom_range(0, int'(cur_width) - 1));
            end
        end
        send_pixel(x, y, frame);
    endtask

    initial begin
        logic [COORD_BITS-1:0] phase_width  [PHASES];
        logic [COORD_BITS-1:0] phase_height [PHASES];
        phase_width  = '{12'd1280, 12'd4095, 12'd1, 12'd7, 12'd0,
                         12'd8, 12'd640, 12'd0, 12'd0, 12'd0};
        phase_height = '{12'd720, 12'd4095, 12'd1, 12'd4, 12'd0,
                         12'd3, 12'd4095, 12'd0, 12'd0, 12'd0};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed beats on the reset geometry: bar edges, band split,
        // scan bar edges, positions outside the frame, extreme frame numbers
        send_pixel(12'd0,    12'd0,    32'd0);
        send_pixel(12'd159,  12'd1,    32'd0);
        send_pixel(12'd160,  12'd1,    32'd0);
        send_pixel(12'd320,  12'd2,    32'd0);
        send_pixel(12'd480,  12'd3,    32'd0);
        send_pixel(12'd640,  12'd4,    32'd0);
        send_pixel(12'd800,  12'd5,    32'd0);
        send_pixel(12'd960,  12'd6,    32'd0);
        send_pixel(12'd1120, 12'd539,  32'd0);
        send_pixel(12'd4095, 12'd0,    32'd0);
        send_pixel(12'd0,    12'd540,  32'd0);
        send_pixel(12'd15,   12'd540,  32'd0);
        send_pixel(12'd16,   12'd540,  32'd0);
        send_pixel(12'd1279, 12'd719,  32'd0);
        send_pixel(12'd319,  12'd700,  32'd1000);
        send_pixel(12'd335,  12'd700,  32'd1000);
        send_pixel(12'd4095, 12'd4095, 32'hFFFFFFFF);
        send_pixel(12'd100,  12'd600,  32'hFFFFFFFF);
        drain_pixels();

        // random phases over several frame geometries
        for (int p = 0; p < PHASES; p++) begin
            if (p >= 7) begin
                phase_width[p]  = COORD_BITS'($urandom_range(1, 4095));
                phase_height[p] = COORD_BITS'($urandom_range(1, 4095));
            end
            if (p != 0) begin
                drain_pixels();
                write_reg(CFG_IDX_WIDTH, phase_width[p]);
                write_reg(CFG_IDX_HEIGHT, phase_height[p]);
            end
            for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
                // mid-phase hold-off until the pipeline is empty
                if (p == 1 && n == PIXELS_PER_PHASE / 2) drain_pixels();
                send_random_pixel();
            end
        end

        drain_pixels();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit
    initial begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[color_bar_test_pattern_pixel.f]
rtl/core/cbp_pkg.sv
rtl/core/cbp_cfg.sv
rtl/core/cbp_front.sv
rtl/core/cbp_div_stage.sv
rtl/core/cbp_back.sv
rtl/core/color_bar_test_pattern_pixel.sv
verif/color_bar_checker.sv
verif/tb_color_bar_test_pattern_pixel.sv
